// ----- src/nirfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nirfd_pkg: shared types, constants and helpers for the NEC IR frame decoder
// Holds the register map, the settings bundle, the item class record and the
// key lookup used when a frame closes.
// -----------------------------------------------------------------------------
package nirfd_pkg;

  localparam int PERIOD_W   = 16;
  localparam int WORD_W     = 32;
  localparam int KEY_W      = 5;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int FRAME_BITS_DEF = 32;
  localparam int Q_DEPTH    = 2;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_LEAD_MIN  = 3'd1;
  localparam logic [2:0] REG_LEAD_MAX  = 3'd2;
  localparam logic [2:0] REG_BIT_MIN   = 3'd3;
  localparam logic [2:0] REG_BIT_MAX   = 3'd4;
  localparam logic [2:0] REG_ONE_THR   = 3'd5;
  localparam logic [2:0] REG_CUSTOM    = 3'd6;

  // reset values
  localparam logic [PERIOD_W-1:0] LEAD_MIN_RST = 16'd12500;
  localparam logic [PERIOD_W-1:0] LEAD_MAX_RST = 16'd14285;
  localparam logic [PERIOD_W-1:0] BIT_MIN_RST  = 16'd1000;
  localparam logic [PERIOD_W-1:0] BIT_MAX_RST  = 16'd3333;
  localparam logic [PERIOD_W-1:0] ONE_THR_RST  = 16'd2000;
  localparam logic [PERIOD_W-1:0] CUSTOM_RST   = 16'h45BA;

  localparam logic [7:0] KEY_FIRST = 8'd1;
  localparam logic [7:0] KEY_LAST  = 8'd21;

  typedef struct packed {
    logic                enable;
    logic [PERIOD_W-1:0] lead_min;
    logic [PERIOD_W-1:0] lead_max;
    logic [PERIOD_W-1:0] bit_min;
    logic [PERIOD_W-1:0] bit_max;
    logic [PERIOD_W-1:0] one_thr;
    logic [PERIOD_W-1:0] custom_code;
  } cfg_t;

  // classification of one period
  typedef struct packed {
    logic lead_hit;
    logic bit_hit;
    logic bit_one;
  } cls_t;

  function automatic logic [KEY_W-1:0] key_of(input logic [WORD_W-1:0] word,
                                              input logic [PERIOD_W-1:0] custom);
    logic [7:0] cmd;
    logic [7:0] inv;
    logic [KEY_W-1:0] key;
    cmd = word[15:8];
    inv = word[7:0];
    key = '0;
    if (word[31:16] == custom && inv == ~cmd && cmd >= KEY_FIRST && cmd <= KEY_LAST) begin
      key = cmd[KEY_W-1:0];
    end
    return key;
  endfunction

endpackage
`default_nettype wire

// ----- src/nirfd_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nirfd_cfg: register bank
// APB-style write/read of the enable flag, the timing windows and the
// expected custom code.
// -----------------------------------------------------------------------------
module nirfd_cfg
  import nirfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:   cfg_nxt.enable      = pwdata[0];
        REG_LEAD_MIN: cfg_nxt.lead_min    = pwdata[PERIOD_W-1:0];
        REG_LEAD_MAX: cfg_nxt.lead_max    = pwdata[PERIOD_W-1:0];
        REG_BIT_MIN:  cfg_nxt.bit_min     = pwdata[PERIOD_W-1:0];
        REG_BIT_MAX:  cfg_nxt.bit_max     = pwdata[PERIOD_W-1:0];
        REG_ONE_THR:  cfg_nxt.one_thr     = pwdata[PERIOD_W-1:0];
        REG_CUSTOM:   cfg_nxt.custom_code = pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b1;
      cfg_r.lead_min    <= LEAD_MIN_RST;
      cfg_r.lead_max    <= LEAD_MAX_RST;
      cfg_r.bit_min     <= BIT_MIN_RST;
      cfg_r.bit_max     <= BIT_MAX_RST;
      cfg_r.one_thr     <= ONE_THR_RST;
      cfg_r.custom_code <= CUSTOM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ENABLE:   prdata = {{(APB_DW-1){1'b0}}, cfg_r.enable};
      REG_LEAD_MIN: prdata = {{(APB_DW-PERIOD_W){1'b0}}, cfg_r.lead_min};
      REG_LEAD_MAX: prdata = {{(APB_DW-PERIOD_W){1'b0}}, cfg_r.lead_max};
      REG_BIT_MIN:  prdata = {{(APB_DW-PERIOD_W){1'b0}}, cfg_r.bit_min};
      REG_BIT_MAX:  prdata = {{(APB_DW-PERIOD_W){1'b0}}, cfg_r.bit_max};
      REG_ONE_THR:  prdata = {{(APB_DW-PERIOD_W){1'b0}}, cfg_r.one_thr};
      REG_CUSTOM:   prdata = {{(APB_DW-PERIOD_W){1'b0}}, cfg_r.custom_code};
      default:      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- src/nirfd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nirfd_front: period classifier
// Accept a period and tag it against the lead window, the bit window and
// the one-threshold.
// -----------------------------------------------------------------------------
module nirfd_front
  import nirfd_pkg::*;
(
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [PERIOD_W-1:0] in_period,
  input  wire cfg_t                cfg,
  input  wire logic                q_full,
  output logic                     q_push,
  output cls_t                     q_wdata
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.lead_hit = (in_period >= cfg.lead_min) && (in_period <= cfg.lead_max);
    q_wdata.bit_hit  = (in_period >= cfg.bit_min)  && (in_period <= cfg.bit_max);
    q_wdata.bit_one  = (in_period >= cfg.one_thr);
  end

endmodule
`default_nettype wire

// ----- src/nirfd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nirfd_queue: class queue
// Short FIFO of classified items between the front and the back.
// -----------------------------------------------------------------------------
module nirfd_queue
  import nirfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cls_t wdata,
  output logic      full,
  input  wire logic pop,
  output logic      rvalid,
  output cls_t      rdata
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cls_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full   = (count_r == CNT_W'(Q_DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- src/nirfd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nirfd_back: frame assembler
// Track the frame state, shift in data bits, close the frame and hold the
// result in the output register.
// -----------------------------------------------------------------------------
module nirfd_back
  import nirfd_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              q_valid,
  input  wire cls_t              q_rdata,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WORD_W-1:0] out_frame_word,
  output logic      [KEY_W-1:0]  out_key_index
);

  localparam int CNT_W = $clog2(FRAME_BITS + 2);

  // 0 = waiting for lead, n+1 = frame open with n bits in
  logic [CNT_W-1:0]  bit_count_r, bit_count_nxt;
  logic [WORD_W-1:0] frame_bits_r, frame_bits_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r;
  logic [KEY_W-1:0]  out_key_r;

  logic [CNT_W-1:0]  cnt_a;
  logic [CNT_W-1:0]  cnt_b;
  logic [WORD_W-1:0] bits_a;
  logic [WORD_W-1:0] word_a;
  logic [31:0]       idx;
  logic [4:0]        pos;
  logic              bit_take;
  logic              done;
  logic              emit;
  logic              out_free;

  always_comb begin
    cnt_a  = bit_count_r;
    bits_a = frame_bits_r;
    // a lead only counts while idle
    if (bit_count_r == '0 && q_rdata.lead_hit) begin
      cnt_a  = CNT_W'(1);
      bits_a = '0;
    end
    bit_take = (cnt_a != '0) && q_rdata.bit_hit;
    idx      = 32'(cnt_a) - 32'd1;
    // bytes arrive LSB first, first byte goes to the top
    pos      = {~idx[4:3], idx[2:0]};
    word_a   = bits_a;
    if (idx < 32'd32 && q_rdata.bit_one) begin
      word_a[pos] = 1'b1;
    end
    cnt_b    = cnt_a + 1'b1;
    done     = bit_take && (cnt_b > CNT_W'(FRAME_BITS));
    emit     = done && cfg.enable;
    out_free = !out_valid_r || !out_stall;
    q_pop    = q_valid && (!emit || out_free);
  end

  always_comb begin
    bit_count_nxt  = bit_count_r;
    frame_bits_nxt = frame_bits_r;
    if (q_pop) begin
      if (done) begin
        bit_count_nxt  = '0;
        frame_bits_nxt = '0;
      end else if (bit_take) begin
        bit_count_nxt  = cnt_b;
        frame_bits_nxt = word_a;
      end else begin
        bit_count_nxt  = cnt_a;
        frame_bits_nxt = bits_a;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= '0;
      frame_bits_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      bit_count_r  <= bit_count_nxt;
      frame_bits_r <= frame_bits_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_word_r <= word_a;
      out_key_r  <= key_of(word_a, cfg.custom_code);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_word = out_word_r;
  assign out_key_index  = out_key_r;

endmodule
`default_nettype wire

// ----- src/nec_ir_frame_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// nec_ir_frame_decoder: NEC-style infrared remote frame decoder
// Turns a stream of measured edge-to-edge periods into 32-bit frame words
// and a matched key number.
// -----------------------------------------------------------------------------
//
//  Channel  | Ports                                   | Direction | Moves
//  ---------+-----------------------------------------+-----------+-------------------
//  in       | in_valid, in_stall, in_period           | sink      | one period per item
//  out      | out_valid, out_stall, out_frame_word,   | source    | one frame per item
//           | out_key_index                           |           |
//  cfg      | psel, penable, pwrite, paddr, pwdata,   | slave     | register access
//           | prdata, pready                          |           |
//
//  One period is accepted every cycle while in_stall is low. Each item is
//  classified on its way into the two-entry queue, then taken by the frame
//  assembler; a closing frame is registered in the output register as its last bit is popped.
//  Reset (rst_n low, synchronous) empties the queue, drops any partial frame,
//  clears the output valid and loads the default windows with enable set.
//  A stall on out only holds up an item that closes a frame with enable set;
//  the queue then fills and in_stall rises once both entries are taken.
//
module nec_ir_frame_decoder
  import nirfd_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // period input
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [PERIOD_W-1:0] in_period,
  // frame output
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [WORD_W-1:0]   out_frame_word,
  output logic      [KEY_W-1:0]    out_key_index,
  // register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready
);

  cfg_t cfg;
  cls_t q_wdata;
  cls_t q_rdata;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;

  // settings live here; the user must change them only while the decoder is idle, the block does not enforce it
  nirfd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // tag each period as lead, bit and bit value; state is not needed here
  nirfd_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_period (in_period),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // decouple the classifier from the assembler so each can stall alone
  nirfd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // apply the tags to the frame state and emit closed frames
  nirfd_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_word (out_frame_word),
    .out_key_index  (out_key_index)
  );

endmodule
`default_nettype wire
